/* rtl/crs_pkg.sv */
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants of the clip rectangle stack
// Request codes, register map and field widths that do not vary.
// ----------------------------------------------------------------------------
package crs_pkg;

  // request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_CLEAR     = 3'd0,
    REQ_SETUP     = 3'd1,
    REQ_PUSH      = 3'd2,
    REQ_INTERSECT = 3'd3,
    REQ_POP       = 3'd4,
    REQ_RESTORE   = 3'd5
  } req_type_t;

  // register index, taken from paddr[2] (registers sit at 4*index)
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam int unsigned IN_W     = 15;   // request coordinate width
  localparam int unsigned OUT_W    = 16;   // reported coordinate width
  localparam int unsigned SCREEN_W = 14;   // screen size register width

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 14'd320;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 14'd240;

endpackage

/* rtl/clip_rect_stack.sv */
// ----------------------------------------------------------------------------
// clip_rect_stack: stack of clip rectangles with translate and intersect
// Top of stack lives in a register; lower entries live in a memory.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction is held in the input register and executed
//   into the result register, which drives out_valid. Throughput: one
//   transaction per cycle unless out_stall or a pop that exposes a stored
//   entry (registered read of the stack memory) holds the input register.
// Reset: stack empty, screen size 320 x 240, no result pending. Stack memory
//   contents stay undefined and are never used before written (no clear pass).
// ----------------------------------------------------------------------------
module clip_rect_stack
  import crs_pkg::*;
#(
  parameter int STACK_DEPTH = 128,
  parameter int COORD_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // request channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              req_type,
  input  logic signed [IN_W-1:0]  rect_left,
  input  logic signed [IN_W-1:0]  rect_top,
  input  logic signed [IN_W-1:0]  rect_width,
  input  logic signed [IN_W-1:0]  rect_height,
  input  logic signed [IN_W-1:0]  offset_x,
  input  logic signed [IN_W-1:0]  offset_y,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    rect_valid,
  output logic signed [OUT_W-1:0] clip_left,
  output logic signed [OUT_W-1:0] clip_top,
  output logic signed [OUT_W-1:0] clip_width,
  output logic signed [OUT_W-1:0] clip_height,
  output logic                    area_nonzero,
  output logic                    overflow,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int W  = COORD_WIDTH;
  localparam int XW = COORD_WIDTH + 4;              // headroom for edge math
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic signed [W-1:0] l;
    logic signed [W-1:0] t;
    logic signed [W-1:0] w;
    logic signed [W-1:0] h;
  } rect_t;

  // sign-extend a stored coordinate to the working width
  function automatic logic signed [XW-1:0] sx(input logic signed [W-1:0] v);
    return {{(XW-W){v[W-1]}}, v};
  endfunction

  // sign-extend a request coordinate to the working width
  function automatic logic signed [XW-1:0] sx_in(input logic signed [IN_W-1:0] v);
    return {{(XW-IN_W){v[IN_W-1]}}, v};
  endfunction

  // wrap a working value to the stored width
  function automatic logic signed [W-1:0] wrap(input logic signed [XW-1:0] v);
    return v[W-1:0];
  endfunction

  // low bits of a stored coordinate as reported
  function automatic logic signed [OUT_W-1:0] rep(input logic signed [W-1:0] v);
    logic signed [XW-1:0] e;
    e = sx(v);
    return e[OUT_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [SCREEN_W-1:0] screen_width;
  logic [SCREEN_W-1:0] screen_height;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_SCREEN_WIDTH) begin
        screen_width <= pwdata[SCREEN_W-1:0];
      end else begin
        screen_height <= pwdata[SCREEN_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SCREEN_WIDTH) ? {{(32-SCREEN_W){1'b0}}, screen_width}
                                                 : {{(32-SCREEN_W){1'b0}}, screen_height};

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic                   in_full;
  logic [2:0]             in_req;
  logic signed [IN_W-1:0] in_l, in_t, in_w, in_h, in_ox, in_oy;
  logic                   exec;
  logic                   slot_free;
  logic                   need_rd;
  logic                   pop_rd;

  assign slot_free = !out_valid || !out_stall;
  assign exec      = in_full && slot_free && (!need_rd || pop_rd);
  assign in_stall  = in_full && !exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (exec) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_req <= req_type;
      in_l   <= rect_left;
      in_t   <= rect_top;
      in_w   <= rect_width;
      in_h   <= rect_height;
      in_ox  <= offset_x;
      in_oy  <= offset_y;
    end
  end

  // --------------------------------------------------------------------------
  // stack state: count, top register, memory for lower entries
  // --------------------------------------------------------------------------
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] count_m1, count_m2;
  rect_t         top, top_next;
  rect_t         mem [STACK_DEPTH];
  rect_t         rd_data;
  rect_t         mem_wd;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;

  assign count_m1 = count - CW'(1);
  assign count_m2 = count - CW'(2);
  assign mem_ra   = count_m2[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  // a pop over two or more entries reads the new top first
  assign need_rd = (in_req == REQ_POP) && (count >= CW'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_rd <= 1'b0;
    end else if (exec) begin
      pop_rd <= 1'b0;
    end else if (in_full && need_rd) begin
      pop_rd <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // request datapath
  // --------------------------------------------------------------------------
  rect_t                scr, cur, req_rect, set_rect, isect_rect;
  logic signed [XW-1:0] rl, rt, rw, rh, pl, pt, pw, ph;
  logic signed [XW-1:0] r_right, r_bot, p_right, p_bot;
  logic signed [XW-1:0] il, it, ir, ib;
  logic                 disjoint;
  logic                 full;

  // full-screen rectangle from the configuration registers
  assign scr.l = '0;
  assign scr.t = '0;
  assign scr.w = wrap({{(XW-SCREEN_W){1'b0}}, screen_width});
  assign scr.h = wrap({{(XW-SCREEN_W){1'b0}}, screen_height});

  // current top, with an empty stack seen as the screen
  assign cur  = (count == '0) ? scr : top;
  assign full = (count == CW'(STACK_DEPTH));

  // untranslated rectangle for setup
  assign set_rect.l = wrap(sx_in(in_l));
  assign set_rect.t = wrap(sx_in(in_t));
  assign set_rect.w = wrap(sx_in(in_w));
  assign set_rect.h = wrap(sx_in(in_h));

  // translated rectangle for push and intersect
  assign req_rect.l = wrap(sx_in(in_l) + sx_in(in_ox));
  assign req_rect.t = wrap(sx_in(in_t) + sx_in(in_oy));
  assign req_rect.w = set_rect.w;
  assign req_rect.h = set_rect.h;

  // intersection against the top at full precision
  assign rl = sx(req_rect.l);
  assign rt = sx(req_rect.t);
  assign rw = sx(req_rect.w);
  assign rh = sx(req_rect.h);
  assign pl = sx(cur.l);
  assign pt = sx(cur.t);
  assign pw = sx(cur.w);
  assign ph = sx(cur.h);

  assign r_right = rl + rw;
  assign r_bot   = rt + rh;
  assign p_right = pl + pw;
  assign p_bot   = pt + ph;

  assign disjoint = (pw == '0) || (ph == '0) || (r_right < pl) || (r_bot < pt) ||
                    (rl > p_right) || (rt > p_bot);

  assign il = (rl < pl) ? pl : rl;
  assign it = (rt < pt) ? pt : rt;
  assign ir = (r_right > p_right) ? p_right : r_right;
  assign ib = (r_bot > p_bot) ? p_bot : r_bot;

  always_comb begin
    if (disjoint) begin
      isect_rect.l = wrap(sx_in(in_ox));
      isect_rect.t = wrap(sx_in(in_oy));
      isect_rect.w = '0;
      isect_rect.h = '0;
    end else begin
      isect_rect.l = wrap(il);
      isect_rect.t = wrap(it);
      isect_rect.w = wrap(ir - il);
      isect_rect.h = wrap(ib - it);
    end
  end

  // next state and result per request
  rect_t res_rect;
  logic  res_valid;
  logic  res_ovf;

  always_comb begin
    count_next = count;
    top_next   = top;
    mem_we     = 1'b0;
    mem_wa     = (count == '0) ? '0 : count_m1[AW-1:0];
    res_rect   = '0;
    res_valid  = 1'b0;
    res_ovf    = 1'b0;
    unique case (req_type_t'(in_req))
      REQ_CLEAR: begin
        top_next   = scr;
        count_next = CW'(1);
        res_rect   = scr;
        res_valid  = 1'b1;
      end
      REQ_SETUP: begin
        top_next   = set_rect;
        count_next = CW'(1);
        res_rect   = set_rect;
        res_valid  = 1'b1;
      end
      REQ_PUSH, REQ_INTERSECT: begin
        res_valid = 1'b1;
        if (full) begin
          res_rect = cur;
          res_ovf  = 1'b1;
        end else begin
          // old top moves down into the memory
          mem_we     = exec;
          top_next   = (in_req == REQ_INTERSECT) ? isect_rect : req_rect;
          count_next = (count == '0) ? CW'(2) : count + CW'(1);
          res_rect   = top_next;
        end
      end
      REQ_POP: begin
        if (count <= CW'(1)) begin
          count_next = '0;
        end else begin
          top_next   = rd_data;
          count_next = count_m1;
          res_rect   = rd_data;
          res_valid  = 1'b1;
        end
      end
      REQ_RESTORE: begin
        if (count == '0) begin
          top_next   = scr;
          count_next = CW'(1);
        end
        res_rect  = cur;
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // memory write data is the current top (screen when empty)
  assign mem_wd = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      top <= top_next;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rect_valid   <= res_valid;
      clip_left    <= rep(res_rect.l);
      clip_top     <= rep(res_rect.t);
      clip_width   <= rep(res_rect.w);
      clip_height  <= rep(res_rect.h);
      area_nonzero <= res_valid && (res_rect.w > 0) && (res_rect.h > 0);
      overflow     <= res_ovf;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_pop_read_held: assert property (@(posedge clk) disable iff (rst)
    pop_rd |-> in_full && (in_req == REQ_POP))
    else $error("pop read phase without a pending pop");

  a_overflow_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> rect_valid && !area_nonzero == !(clip_width > 0 &&
      clip_height > 0))
    else $error("overflow result without an active rectangle");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rect_valid |-> clip_width == '0 && clip_height == '0 &&
      !area_nonzero && !overflow)
    else $error("inactive result carries data");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    exec && mem_we |=> count == $past(count_next) && count >= CW'(2))
    else $error("push did not grow the stack");

endmodule
